// ===== design/pwld_pkg.sv =====
// Package for the pulse width level debouncer.
// Holds sizes, register codes, reset values and shared types; no dependencies.
package pwld_pkg;

  localparam int unsigned NUM_LEVELS    = 4;
  localparam int unsigned NumLevelRegs  = 4;
  localparam int unsigned NumCompared   =
      (NUM_LEVELS < NumLevelRegs) ? NUM_LEVELS : NumLevelRegs;

  localparam int unsigned WidthW    = 15;
  localparam int unsigned GraceW    = 10;
  localparam int unsigned CountW    = 8;
  localparam int unsigned LevelW    = 2;
  localparam int unsigned CfgIndexW = 3;
  localparam int unsigned CfgDataW  = 15;

  localparam logic [WidthW-1:0] TimeoutUs = WidthW'(30000);

  typedef enum logic [CfgIndexW-1:0] {
    RegLevel0   = 3'd0,
    RegLevel1   = 3'd1,
    RegLevel2   = 3'd2,
    RegLevel3   = 3'd3,
    RegGrace    = 3'd4,
    RegDebounce = 3'd5
  } cfg_reg_e;

  typedef logic [NumLevelRegs-1:0][WidthW-1:0] level_widths_t;

  localparam level_widths_t LevelWidthsRst = {
    WidthW'(2000), WidthW'(1667), WidthW'(1333), WidthW'(1000)
  };
  localparam logic [GraceW-1:0] GraceRst    = GraceW'(100);
  localparam logic [CountW-1:0] DebounceRst = CountW'(3);

  typedef struct packed {
    logic              hit;
    logic [LevelW-1:0] index;
  } match_t;

endpackage

// ===== design/pwld_match.sv =====
// Window match of one pulse width against the nominal level widths.
// Depends on pwld_pkg; pure combinational logic.
module pwld_match (
  input  logic [pwld_pkg::WidthW-1:0] pulse_width_i,
  input  pwld_pkg::level_widths_t     level_widths_i,
  input  logic [pwld_pkg::GraceW-1:0] grace_i,
  output pwld_pkg::match_t            match_o
);
  import pwld_pkg::*;

  logic [NumCompared-1:0] hit;

  // w > nom - g && w < nom + g, rearranged so nothing goes negative
  always_comb begin
    for (int i = 0; i < NumCompared; i++) begin
      hit[i] = (({1'b0, pulse_width_i} + {6'd0, grace_i}) > {1'b0, level_widths_i[i]}) &&
               ({1'b0, pulse_width_i} < ({1'b0, level_widths_i[i]} + {6'd0, grace_i}));
    end
  end

  // lowest-numbered hit wins: scan downward so the last write is the lowest
  always_comb begin
    match_o = '0;
    for (int i = NumCompared - 1; i >= 0; i--) begin
      if (hit[i]) begin
        match_o.hit   = 1'b1;
        match_o.index = LevelW'(i);
      end
    end
  end

endmodule

// ===== design/pulse_width_level_debouncer_top.sv =====
// Top level of the pulse width level debouncer.
// Depends on pwld_pkg and pwld_match.
//
// Each input word is a measured pulse width in microseconds. It is matched
// against the configured level widths (strict window of +/- grace), the lowest
// matching level becomes the requested level, and a differing request is
// adopted as the active level only once the debounce count has reached the
// configured value. One result word comes back per input word. An input word
// is registered, then classified and folded into the debounce state in one
// pass into the output register, so a new word is taken every cycle unless
// the output is stalled; the output register holds a stalled result while
// the input register takes the next word.
// Configuration writes are taken at any time through cfg_we_i, but should only
// be issued while no word is in flight.
module pulse_width_level_debouncer_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [pwld_pkg::CfgIndexW-1:0]  cfg_index_i,
  input  logic [pwld_pkg::CfgDataW-1:0]   cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [pwld_pkg::WidthW-1:0]     pulse_width_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [pwld_pkg::LevelW-1:0]     active_level_o,
  output logic                            level_changed_o,
  output logic [pwld_pkg::LevelW-1:0]     requested_level_o
);
  import pwld_pkg::*;

  // configuration
  level_widths_t       level_widths_q;
  logic [GraceW-1:0]   grace_q;
  logic [CountW-1:0]   debounce_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_widths_q <= LevelWidthsRst;
      grace_q        <= GraceRst;
      debounce_q     <= DebounceRst;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegLevel0:   level_widths_q[0] <= cfg_wdata_i[WidthW-1:0];
        RegLevel1:   level_widths_q[1] <= cfg_wdata_i[WidthW-1:0];
        RegLevel2:   level_widths_q[2] <= cfg_wdata_i[WidthW-1:0];
        RegLevel3:   level_widths_q[3] <= cfg_wdata_i[WidthW-1:0];
        RegGrace:    grace_q           <= cfg_wdata_i[GraceW-1:0];
        RegDebounce: debounce_q        <= cfg_wdata_i[CountW-1:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic              in_valid_q;
  logic [WidthW-1:0] width_q;
  logic              out_valid_q;
  logic              advance;

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      width_q <= pulse_width_i;
    end
  end

  // classification
  match_t match;

  pwld_match u_match (
    .pulse_width_i  (width_q),
    .level_widths_i (level_widths_q),
    .grace_i        (grace_q),
    .match_o        (match)
  );

  // debounce state
  logic [LevelW-1:0] requested_q, requested_d;
  logic [LevelW-1:0] active_q, active_d;
  logic [LevelW-1:0] candidate_q, candidate_d;
  logic [CountW-1:0] count_q, count_d;
  logic              changed_d;

  always_comb begin
    requested_d = match.hit ? match.index : requested_q;
    active_d    = active_q;
    candidate_d = candidate_q;
    count_d     = '0;
    changed_d   = 1'b0;
    if (active_q == requested_d) begin
      count_d = '0;
    end else if (count_q >= debounce_q) begin
      active_d  = requested_d;
      changed_d = 1'b1;
    end else if (candidate_q == requested_d) begin
      count_d = count_q + CountW'(1);
    end else begin
      candidate_d = requested_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      requested_q <= '0;
      active_q    <= '0;
      candidate_q <= '0;
      count_q     <= '0;
    end else if (advance) begin
      requested_q <= requested_d;
      active_q    <= active_d;
      candidate_q <= candidate_d;
      count_q     <= count_d;
    end
  end

  // result register
  logic changed_q;

  always_ff @(posedge clk_i) begin
    if (advance) begin
      changed_q <= changed_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign active_level_o    = active_q;
  assign requested_level_o = requested_q;
  assign level_changed_o   = changed_q;

endmodule

// ===== design/pwld_checker.sv =====
// Port-level checks for the pulse width level debouncer, bound to the top.
// Depends on pwld_pkg and pulse_width_level_debouncer_top.
module pwld_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_ready_o,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [pwld_pkg::LevelW-1:0] active_level_o,
  input logic                        level_changed_o,
  input logic [pwld_pkg::LevelW-1:0] requested_level_o
);
  import pwld_pkg::*;

  // active level of the last word delivered
  logic [LevelW-1:0] last_active_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_active_q <= '0;
    end else if (out_valid_o && out_ready_i) begin
      last_active_q <= active_level_o;
    end
  end

  // the active level moves exactly when a word is flagged as a change
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (level_changed_o == (active_level_o != last_active_q)))
    else $error("level_changed does not match a move of the active level");

  // a change always adopts the requested level
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && level_changed_o) |-> (active_level_o == requested_level_o))
    else $error("changed word whose active level is not the requested one");

  // an empty output register never blocks the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled while output register is empty");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(active_level_o) && $stable(level_changed_o) &&
       $stable(requested_level_o)))
    else $error("stalled result word changed");

endmodule

bind pulse_width_level_debouncer_top pwld_checker u_pwld_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_ready_o        (in_ready_o),
  .out_valid_o       (out_valid_o),
  .out_ready_i       (out_ready_i),
  .active_level_o    (active_level_o),
  .level_changed_o   (level_changed_o),
  .requested_level_o (requested_level_o)
);
